// ----- rtl/core/pixel_replicating_upscaler_macros.svh -----
// Assertion macros for the upscaler port checker
`ifndef PIXEL_REPLICATING_UPSCALER_MACROS_SVH
`define PIXEL_REPLICATING_UPSCALER_MACROS_SVH

// Check a property on every clock edge outside reset
`define PRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define PRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pru_pkg.sv -----
// Types and constants of the pixel replicating upscaler
package pru_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_SCALE = 16;

  localparam int SCALE_W = 5;
  localparam int WIDTH_W = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int PASS_W  = 4;
  localparam int CNT_W   = $clog2(MAX_SCALE + 1);
  localparam int PAD_W   = 2;
  localparam int PIX_W   = 24;
  localparam int CFG_W   = 12;

  // Input item kinds
  localparam logic ITEM_PIXEL = 1'b0;
  localparam logic ITEM_TICK  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_PAD    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_IDLE   = 2'd3;

  // Register indexes
  localparam logic REG_SCALE     = 1'b0;
  localparam logic REG_ROW_WIDTH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } sample_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       last;
  } result_t;

endpackage

// ----- rtl/core/pixel_replicating_upscaler.sv -----
// Nearest-neighbor 24-bit row upscaler with line buffer and replay
// Flow: an accepted item is loaded into the job registers, then its results leave through the
//   output register: scale pixels for a pixel or tick, plus (row_width*scale mod 4) pads at
//   row end, or one result for a rejected pixel or idle tick. The result emitter sets the pace.
// Reset: rst clears the registers (scale 1, row width 1), column and pass counters and
//   handshake state; the 2048-entry line store is not cleared.
module pixel_replicating_upscaler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [pru_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  pru_pkg::sample_t             sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output pru_pkg::result_t             result
);
  import pru_pkg::*;

  // Configuration registers
  logic [SCALE_W-1:0] scale;
  logic [WIDTH_W-1:0] row_width;

  // Row state
  logic [COL_W-1:0]  write_column;
  logic [COL_W-1:0]  replay_column;
  logic [PASS_W-1:0] replay_passes_left;

  // Line buffer
  logic [PIX_W-1:0] line_store [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data;

  // Job being emitted
  logic             job_valid;
  logic             job_single;
  logic [1:0]       job_code;
  logic             job_use_rd;
  logic [PIX_W-1:0] job_pix;
  logic [CNT_W-1:0] job_pix_cnt;
  logic [PAD_W-1:0] job_pad_cnt;

  logic [SCALE_W-1:0] s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [PAD_W-1:0]   pad_len;
  logic               accept;
  logic               out_free;
  logic               emit;
  logic               job_done;
  logic               wr_end_row;
  logic               rd_end_row;
  logic               mem_we;
  logic               mem_re;
  logic [PIX_W-1:0]   in_pix;
  logic [PIX_W-1:0]   cur_pix;
  result_t            cur;

  // Clamp the registers to their working ranges
  always_comb begin
    if (scale == '0) begin
      s_eff = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale;
    end
    if (row_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (row_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = row_width;
    end
  end

  // Pad bytes: (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4
  assign pad_len = PAD_W'(w_eff[1:0] * s_eff[1:0]);

  assign in_pix     = {sample.red, sample.green, sample.blue};
  assign wr_end_row = ({1'b0, write_column} + WIDTH_W'(1)) >= w_eff;
  assign rd_end_row = ({1'b0, replay_column} + WIDTH_W'(1)) >= w_eff;

  // Form the current result of the job
  always_comb begin
    cur_pix = job_use_rd ? rd_data : job_pix;
    cur     = '0;
    if (job_single) begin
      cur.out_kind = job_code;
      cur.last     = 1'b1;
    end else if (job_pix_cnt != '0) begin
      cur.out_kind  = KIND_PIXEL;
      cur.out_blue  = cur_pix[7:0];
      cur.out_green = cur_pix[15:8];
      cur.out_red   = cur_pix[23:16];
      cur.last      = (job_pix_cnt == CNT_W'(1)) && (job_pad_cnt == '0);
    end else begin
      cur.out_kind = KIND_PAD;
      cur.last     = (job_pad_cnt == PAD_W'(1));
    end
  end

  // Handshake: take a new item as the job hands over its final result
  assign out_free     = !result_valid || !result_stall;
  assign emit         = job_valid && out_free;
  assign job_done     = emit && cur.last;
  assign sample_stall = job_valid && !job_done;
  assign accept       = sample_valid && !sample_stall;

  assign mem_we = accept && (sample.kind == ITEM_PIXEL) && (replay_passes_left == '0);
  assign mem_re = accept && (sample.kind == ITEM_TICK) && (replay_passes_left != '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_W'(1);
      row_width <= WIDTH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:     scale     <= cfg_data[SCALE_W-1:0];
        REG_ROW_WIDTH: row_width <= cfg_data[WIDTH_W-1:0];
        default:       ;
      endcase
    end
  end

  // Line buffer write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[write_column] <= in_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= line_store[replay_column];
    end
  end

  // Advance row state on each stored pixel or replayed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      write_column       <= '0;
      replay_column      <= '0;
      replay_passes_left <= '0;
    end else if (mem_we) begin
      if (wr_end_row) begin
        write_column       <= '0;
        replay_column      <= '0;
        replay_passes_left <= PASS_W'(s_eff - SCALE_W'(1));
      end else begin
        write_column <= write_column + COL_W'(1);
      end
    end else if (mem_re) begin
      if (rd_end_row) begin
        replay_column      <= '0;
        replay_passes_left <= replay_passes_left - PASS_W'(1);
      end else begin
        replay_column <= replay_column + COL_W'(1);
      end
    end
  end

  // Load a new job, or step the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_pix     <= in_pix;
      job_pix_cnt <= CNT_W'(s_eff);
      if (sample.kind == ITEM_PIXEL) begin
        job_single  <= (replay_passes_left != '0);
        job_code    <= KIND_REJECT;
        job_use_rd  <= 1'b0;
        job_pad_cnt <= wr_end_row ? pad_len : '0;
      end else begin
        job_single  <= (replay_passes_left == '0);
        job_code    <= KIND_IDLE;
        job_use_rd  <= 1'b1;
        job_pad_cnt <= rd_end_row ? pad_len : '0;
      end
    end else if (emit && !job_single) begin
      if (job_pix_cnt != '0) begin
        job_pix_cnt <= job_pix_cnt - CNT_W'(1);
      end else begin
        job_pad_cnt <= job_pad_cnt - PAD_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result <= cur;
    end
  end

endmodule

// ----- rtl/core/pru_checker.sv -----
// Port checker for the pixel replicating upscaler, bound to the top level
`include "pixel_replicating_upscaler_macros.svh"

module pru_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input pru_pkg::sample_t sample,
  input logic             result_valid,
  input logic             result_stall,
  input pru_pkg::result_t result
);
  import pru_pkg::*;

  // Reset empties the output stage
  `PRU_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid right after reset")

  // A held result keeps its payload
  `PRU_ASSERT(a_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  // Reject and idle answers stand alone
  `PRU_ASSERT(a_single_last, result_valid && (result.out_kind == KIND_REJECT || result.out_kind == KIND_IDLE) |-> result.last, "reject or idle result without last")

  // Only pixels carry color bytes
  `PRU_ASSERT(a_zero_bytes, result_valid && result.out_kind != KIND_PIXEL |-> result.out_blue == 8'd0 && result.out_green == 8'd0 && result.out_red == 8'd0, "non-pixel result carries data")

endmodule

bind pixel_replicating_upscaler pru_checker u_pru_checker (.*);
